// File: hdl/bdcc_pkg.sv
// ----------------------------------------------------------------------------
// bdcc_pkg
// Shared types and constants for the button debounce / click classifier.
// ----------------------------------------------------------------------------
package bdcc_pkg;

	localparam int TIME_W  = 32;
	localparam int MS_W    = 16;
	localparam int TALLY_W = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [TALLY_W-1:0] TALLY_MAX = '1;
	localparam logic [TALLY_W-1:0] TALLY_TWO   = TALLY_W'(2);
	localparam logic [TALLY_W-1:0] TALLY_THREE = TALLY_W'(3);

	localparam logic [MS_W-1:0] DEBOUNCE_RST = MS_W'(50);
	localparam logic [MS_W-1:0] LONG_RST     = MS_W'(1000);
	localparam logic [MS_W-1:0] WINDOW_RST   = MS_W'(400);

	// Button level encoding (active-low pin)
	localparam logic LVL_RELEASED = 1'b1;
	localparam logic LVL_PRESSED  = 1'b0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE = 2'd0,
		CFG_LONG     = 2'd1,
		CFG_WINDOW   = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [MS_W-1:0] settle_ms;
		logic [MS_W-1:0] hold_min_ms;
		logic [MS_W-1:0] multi_click_window_ms;
	} cfg_t;

	typedef struct packed {
		logic press_event;
		logic short_press;
		logic long_press;
		logic double_click;
		logic triple_click;
		logic multi_click;
		logic release_verdict;
		logic stable_level_out;
	} res_t;

endpackage

// File: hdl/bdcc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bdcc_cfg_regs
// Configuration register file: debounce, long press and click window times.
// ----------------------------------------------------------------------------
module bdcc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [bdcc_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [bdcc_pkg::MS_W-1:0]     wr_data,
	output bdcc_pkg::cfg_t                cfg
);
	import bdcc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_ms             <= DEBOUNCE_RST;
			cfg_q.hold_min_ms           <= LONG_RST;
			cfg_q.multi_click_window_ms <= WINDOW_RST;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_DEBOUNCE: cfg_q.settle_ms             <= wr_data;
				CFG_LONG:     cfg_q.hold_min_ms           <= wr_data;
				CFG_WINDOW:   cfg_q.multi_click_window_ms <= wr_data;
				default:      ; // unmapped index, dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hdl/bdcc_engine.sv
// ----------------------------------------------------------------------------
// bdcc_engine
// Debounce and click state plus the single-pass per-poll update.
// ----------------------------------------------------------------------------
module bdcc_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic                        raw,
	input  logic [bdcc_pkg::TIME_W-1:0] now,
	input  bdcc_pkg::cfg_t              cfg,
	output bdcc_pkg::res_t              res
);
	import bdcc_pkg::*;

	logic                last_raw_q;
	logic                deb_q;
	logic [TIME_W-1:0]   last_change_q;
	logic [TIME_W-1:0]   press_start_q;
	logic [TIME_W-1:0]   last_click_q;
	logic [TALLY_W-1:0]  tally_q;

	logic                changed;
	logic [TIME_W-1:0]   elapsed;
	logic                settle;
	logic                press_edge;
	logic                rel_edge;
	logic [TIME_W-1:0]   held;
	logic                is_long;
	logic                is_click;
	logic [TALLY_W-1:0]  tally_inc;
	logic [TALLY_W-1:0]  tally_mid;
	logic                deb_new;
	logic [TIME_W-1:0]   quiet;
	logic                verdict;

	always_comb begin
		changed    = (raw != last_raw_q);
		// a fresh change restarts the timer at now: zero elapsed
		elapsed    = changed ? '0 : (now - last_change_q);
		settle     = (elapsed >= {{(TIME_W-MS_W){1'b0}}, cfg.settle_ms});
		press_edge = settle && (deb_q == LVL_RELEASED) && (raw == LVL_PRESSED);
		rel_edge   = settle && (deb_q == LVL_PRESSED) && (raw == LVL_RELEASED);
		held       = now - press_start_q;
		is_long    = rel_edge && (held >= {{(TIME_W-MS_W){1'b0}}, cfg.hold_min_ms});
		is_click   = rel_edge && !is_long;
		tally_inc  = (tally_q == TALLY_MAX) ? tally_q : (tally_q + TALLY_W'(1));
		priority if (is_long)  tally_mid = '0;
		else if (is_click)     tally_mid = tally_inc;
		else                   tally_mid = tally_q;
		deb_new    = settle ? raw : deb_q;
		quiet      = is_click ? '0 : (now - last_click_q);
		verdict    = (tally_mid != '0) && (deb_new == LVL_RELEASED) &&
			(quiet >= {{(TIME_W-MS_W){1'b0}}, cfg.multi_click_window_ms});

		res.press_event      = press_edge;
		res.long_press       = is_long;
		res.short_press      = verdict && (tally_mid == TALLY_W'(1));
		res.multi_click      = verdict && (tally_mid > TALLY_W'(1));
		res.double_click     = verdict && (tally_mid == TALLY_TWO);
		res.triple_click     = verdict && (tally_mid == TALLY_THREE);
		res.release_verdict  = res.short_press || is_long || res.multi_click;
		res.stable_level_out = deb_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q    <= LVL_RELEASED;
			deb_q         <= LVL_RELEASED;
			last_change_q <= '0;
			press_start_q <= '0;
			last_click_q  <= '0;
			tally_q       <= '0;
		end else if (step) begin
			last_raw_q <= raw;
			deb_q      <= deb_new;
			tally_q    <= verdict ? '0 : tally_mid;
			if (changed)    last_change_q <= now;
			if (press_edge) press_start_q <= now;
			if (is_click)   last_click_q  <= now;
		end
	end

	// a long release clears the click tally
	a_no_tally_on_long: assert property (@(posedge clk) disable iff (!arst_n)
		step && is_long |=> tally_q == '0)
		else $error("tally survived a long release");

	a_press_level: assert property (@(posedge clk) disable iff (!arst_n)
		step && press_edge |=> deb_q == LVL_PRESSED && press_start_q == $past(now))
		else $error("press edge did not latch level/time");

	a_verdict_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && verdict |=> tally_q == '0 && deb_q == LVL_RELEASED)
		else $error("verdict left tally pending");

	a_edges_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(press_edge && rel_edge))
		else $error("press and release edge together");

endmodule

// File: hdl/button_debounce_click_classifier_core.sv
// ----------------------------------------------------------------------------
// button_debounce_click_classifier_core
// Debounces an active-low button poll stream and classifies presses into
// press, long press and short/double/triple/multi click verdicts.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | dir | word
//  --------+-------------------------------------------+-----+------------------
//  in      | in_valid/in_ready, raw_level, now_ms      | in  | one poll
//  out     | out_valid/out_ready, press_event .. level | out | one result per poll
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data  | in  | one register write
//
//  - One poll per cycle sustained while out_ready is high: a word is
//    registered in the s1 stage, the engine update runs in one combinational
//    pass, and the result lands in the output register; out_valid rises when
//    the word moves from s1 into an output register that is free or being read.
//  - Engine state advances only when the s1 word moves into the output
//    register, so the next poll always sees the state its predecessor left.
//  - A stalled output holds its word; s1 keeps one more, in_ready drops only
//    when both are full and out_ready is low.
//  - Reset (arst_n low) empties both stages and restores register defaults
//    (50 / 1000 / 400 ms) and the released button state.
//  - cfg_ready is always high; writes to an index past the list are dropped.
// ----------------------------------------------------------------------------
module button_debounce_click_classifier_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// poll input
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          raw_level,
	input  logic [bdcc_pkg::TIME_W-1:0]   now_ms,
	// result output
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          press_event,
	output logic                          short_press,
	output logic                          long_press,
	output logic                          double_click,
	output logic                          triple_click,
	output logic                          multi_click,
	output logic                          release_verdict,
	output logic                          stable_level_out,
	// configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bdcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bdcc_pkg::MS_W-1:0]     cfg_data
);
	import bdcc_pkg::*;

	cfg_t              cfg;
	res_t              res;
	res_t              res_q;
	logic              out_v_q;
	logic              v_s1;
	logic              raw_s1;
	logic [TIME_W-1:0] now_s1;
	logic              advance;   // s1 word moves to output register
	logic              in_fire;

	// --- configuration -------------------------------------------------------
	assign cfg_ready = 1'b1;

	bdcc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// --- handshake -----------------------------------------------------------
	assign advance  = v_s1 && (!out_v_q || out_ready);
	assign in_ready = !v_s1 || advance;
	assign in_fire  = in_valid && in_ready;

	// --- s1: input register --------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			raw_s1 <= raw_level;
			now_s1 <= now_ms;
		end
	end

	// --- per-poll update -----------------------------------------------------
	bdcc_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.raw    (raw_s1),
		.now    (now_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// --- result register -----------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid        = out_v_q;
	assign press_event      = res_q.press_event;
	assign short_press      = res_q.short_press;
	assign long_press       = res_q.long_press;
	assign double_click     = res_q.double_click;
	assign triple_click     = res_q.triple_click;
	assign multi_click      = res_q.multi_click;
	assign release_verdict  = res_q.release_verdict;
	assign stable_level_out = res_q.stable_level_out;

	// --- checks --------------------------------------------------------------
	a_click_kinds: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> !(res_q.short_press && res_q.multi_click) &&
			(!(res_q.double_click || res_q.triple_click) || res_q.multi_click))
		else $error("inconsistent click verdict");

	a_verdict_or: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> res_q.release_verdict ==
			(res_q.short_press || res_q.long_press || res_q.multi_click))
		else $error("release_verdict mismatch");

	a_edge_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && res_q.press_event |-> !res_q.stable_level_out && !res_q.release_verdict)
		else $error("press edge with released level");

	a_accept_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_v_q |-> in_ready)
		else $error("input stalled with empty output");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_v_q)
		else $error("advanced word lost");

endmodule
